FILE: rtl/vrt_pkg.sv
`timescale 1ns / 1ps
package vrt_pkg;

  // Command codes carried in tuser
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  localparam logic [24:0] FracOne = 25'h100_0000;

  // One queued request
  typedef struct packed {
    cmd_e                     cmd;
    logic [2:0][31:0]         origin;
    logic [2:0][17:0]         dir;
  } req_t;

endpackage

FILE: rtl/vrt_front.sv
`timescale 1ns / 1ps
module vrt_front import vrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [151:0] s_tdata_i,
  input  logic         s_tuser_i,
  output logic         deq_valid_o,
  input  logic         deq_ready_i,
  output req_t         deq_req_o
);

  req_t       queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  req_t       req;

  // Unpack and classify the incoming request
  always_comb begin
    req.cmd       = cmd_e'(s_tuser_i);
    req.origin[0] = s_tdata_i[31:0];
    req.origin[1] = s_tdata_i[63:32];
    req.origin[2] = s_tdata_i[95:64];
    req.dir[0]    = s_tdata_i[113:96];
    req.dir[1]    = s_tdata_i[131:114];
    req.dir[2]    = s_tdata_i[149:132];
  end

  assign s_tready_o  = (count_q != 2'd2);
  assign push        = s_tvalid_i && s_tready_o;
  assign deq_valid_o = (count_q != 2'd0);
  assign pop         = deq_valid_o && deq_ready_i;
  assign deq_req_o   = queue_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= req;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("pointer mismatch");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |=> (count_q != 2'd0)) else $error("queue drained too fast");

endmodule

FILE: rtl/vrt_back.sv
`timescale 1ns / 1ps
module vrt_back import vrt_pkg::*; #(
  parameter int unsigned STEP_LIMIT = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] cell_size_i,
  input  logic        deq_valid_i,
  output logic        deq_ready_o,
  input  req_t        deq_req_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,
  output logic [1:0]  m_tuser_o
);

  localparam int unsigned CntW = $clog2(STEP_LIMIT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_MSEL = 3'd4;
  localparam logic [2:0] S_MHI  = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        st_q;
  cmd_e              op_q;
  logic [1:0]        axis_q;
  logic [5:0]        it_q;
  logic [55:0]       num_q, quo_q;
  logic [24:0]       rem_q;
  logic [23:0]       den_q;
  logic              neg_q;
  logic [1:0]        best_q;
  logic              bestv_q;
  logic [40:0]       bt_q;
  logic [58:0]       prod_q;
  logic [2:0][15:0]  idx_q;
  logic [2:0][24:0]  frac_q;
  logic [2:0][17:0]  dir_q;
  logic [2:0][31:0]  org_q;
  logic [CntW-1:0]   cnt_q;
  logic [47:0]       rep_q;
  logic              out_v_q;
  logic [47:0]       out_d_q;
  logic [1:0]        out_u_q;

  // Per-axis values for the current axis
  logic [17:0] dir_a, dmag;
  logic [31:0] org_a, omag;
  logic [24:0] frac_a, remain;
  logic [24:0] rem_sh;
  logic        qbit;
  logic [39:0] qm, qs;
  logic [40:0] tq;
  logic [42:0] delta;
  logic [43:0] fsum;
  logic [23:0] size;
  logic [41:0] prod_lo;
  logic [34:0] prod_hi;

  always_comb begin
    dir_a   = dir_q[axis_q];
    org_a   = org_q[axis_q];
    frac_a  = frac_q[axis_q];
    dmag    = dir_a[17] ? 18'(-dir_a) : dir_a;
    omag    = org_a[31] ? 32'(-org_a) : org_a;
    remain  = dir_a[17] ? frac_a : 25'(FracOne - frac_a);
    rem_sh  = {rem_q[23:0], num_q[55]};
    qbit    = (rem_sh >= {1'b0, den_q});
    qm      = quo_q[39:0] + {39'd0, (neg_q && (rem_q != 25'd0))};
    qs      = neg_q ? 40'(-qm) : qm;
    tq      = quo_q[40:0];
    delta   = prod_q[58:16];
    fsum    = {19'd0, frac_a} + {1'b0, delta};
    size    = (cell_size_i == 24'd0) ? 24'd1 : cell_size_i;
    prod_lo = {18'd0, bt_q[23:0]} * {24'd0, dmag};
    prod_hi = {18'd0, bt_q[40:24]} * {17'd0, dmag};
  end

  assign deq_ready_o = (st_q == S_IDLE);
  assign m_tvalid_o  = out_v_q;
  assign m_tdata_o   = out_d_q;
  assign m_tuser_o   = out_u_q;

  // Payload of the result register
  always_ff @(posedge clk_i) begin
    if (st_q == S_OUT && (!out_v_q || m_tready_i)) begin
      out_d_q <= rep_q;
      out_u_q <= bestv_q ? best_q : 2'd0;
    end
  end

  // Load or drop the result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (st_q == S_OUT && (!out_v_q || m_tready_i)) begin
      out_v_q <= 1'b1;
    end else if (m_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  // Sequencer: shared divider and split multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      op_q    <= CMD_START;
      axis_q  <= 2'd0;
      it_q    <= 6'd0;
      num_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      den_q   <= 24'd1;
      neg_q   <= 1'b0;
      best_q  <= 2'd0;
      bestv_q <= 1'b0;
      bt_q    <= '0;
      prod_q  <= '0;
      idx_q   <= '0;
      frac_q  <= '0;
      dir_q   <= '0;
      org_q   <= '0;
      cnt_q   <= '0;
      rep_q   <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (deq_valid_i) begin
            op_q   <= deq_req_i.cmd;
            axis_q <= 2'd0;
            if (deq_req_i.cmd == CMD_START) begin
              org_q <= deq_req_i.origin;
              dir_q <= deq_req_i.dir;
              st_q  <= S_LOAD;
            end else if (cnt_q < CntW'(STEP_LIMIT)) begin
              cnt_q   <= cnt_q + 1'b1;
              rep_q   <= {idx_q[2], idx_q[1], idx_q[0]};
              bestv_q <= 1'b0;
              st_q    <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          rem_q <= '0;
          quo_q <= '0;
          if (op_q == CMD_START) begin
            num_q <= {omag, 24'd0};
            den_q <= size;
            neg_q <= org_a[31];
            it_q  <= 6'd56;
            st_q  <= S_DIV;
          end else if (dir_a == 18'd0) begin
            if (axis_q == 2'd2) begin
              axis_q <= 2'd0;
              st_q   <= bestv_q ? S_MSEL : S_OUT;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            num_q <= {remain, 31'd0};
            den_q <= {6'd0, dmag};
            neg_q <= 1'b0;
            it_q  <= 6'd41;
            st_q  <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= qbit ? 25'(rem_sh - {1'b0, den_q}) : rem_sh;
          quo_q <= {quo_q[54:0], qbit};
          num_q <= {num_q[54:0], 1'b0};
          it_q  <= it_q - 6'd1;
          if (it_q == 6'd1) st_q <= S_DONE;
        end
        S_DONE: begin
          if (op_q == CMD_START) begin
            idx_q[axis_q]  <= qs[39:24];
            frac_q[axis_q] <= {1'b0, qs[23:0]};
            if (axis_q == 2'd2) begin
              cnt_q <= '0;
              st_q  <= S_IDLE;
            end else begin
              axis_q <= axis_q + 2'd1;
              st_q   <= S_LOAD;
            end
          end else begin
            if (!bestv_q || tq < bt_q) begin
              best_q  <= axis_q;
              bt_q    <= tq;
              bestv_q <= 1'b1;
            end
            if (axis_q == 2'd2) begin
              axis_q <= 2'd0;
              st_q   <= S_MSEL;
            end else begin
              axis_q <= axis_q + 2'd1;
              st_q   <= S_LOAD;
            end
          end
        end
        S_MSEL: begin
          if (axis_q == best_q || dir_a == 18'd0) begin
            if (axis_q == 2'd2) begin
              st_q <= S_OUT;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            prod_q <= {17'd0, prod_lo};
            st_q   <= S_MHI;
          end
        end
        S_MHI: begin
          prod_q <= prod_q + {prod_hi, 24'd0};
          st_q   <= S_UPD;
        end
        S_UPD: begin
          if (!dir_a[17]) begin
            frac_q[axis_q] <= (fsum > {19'd0, FracOne}) ? FracOne : fsum[24:0];
          end else begin
            frac_q[axis_q] <= ({18'd0, frac_a} >= delta) ? 25'(frac_a - delta[24:0])
                                                          : 25'd0;
          end
          // revisit select for the next axis
          if (axis_q != 2'd2) begin
            axis_q <= axis_q + 2'd1;
            st_q   <= S_MSEL;
          end else begin
            st_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_v_q || m_tready_i) begin
            // advance the stepped axis once the report is loaded
            if (bestv_q) begin
              idx_q[best_q]  <= dir_q[best_q][17] ? idx_q[best_q] - 16'd1
                                                  : idx_q[best_q] + 16'd1;
              frac_q[best_q] <= dir_q[best_q][17] ? FracOne : 25'd0;
            end
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (den_q != 24'd0)) else $error("divide by zero");
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STEP_LIMIT)) else $error("step count over limit");
  a_upd_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_UPD) |-> (axis_q != best_q && bestv_q)) else $error("stepped axis moved");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (rem_q < {1'b0, den_q})) else $error("remainder too large");

endmodule

FILE: rtl/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// Channel   | Dir | Contents
// s_axis    | in  | tdata: origin_x/y/z (32 each), dir_x/y/z (18 each); tuser: command
// m_axis    | out | tdata: voxel_x/y/z (16 each); tuser: axis_stepped
// cell_size | in  | write enable and 24-bit data
// Start: three 56-step divisions by the voxel size.
// Step: accept, then for each axis a 41-step division if its direction is non-zero,
// else a skip; then an update pass that multiplies for each moved axis; then output.
// The divider is shared by the axes in turn. A full result register holds the engine.
// A two-entry queue decouples input acceptance from the engine.
// Reset clears all ray state and control; no clearing pass.
// Steps past the limit and start commands produce no output.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int unsigned STEP_LIMIT = 100
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cell_size_we_i,
  input  logic [23:0]  cell_size_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // voxel_x, voxel_y, voxel_z
  output logic [1:0]   m_axis_tuser    // axis_stepped
);

  logic [23:0] cell_size_q;
  logic        deq_valid, deq_ready;
  req_t        deq_req;

  // Hold the voxel size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 24'd6554;
    end else if (cell_size_we_i) begin
      cell_size_q <= cell_size_i;
    end
  end

  vrt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_req_o   (deq_req)
  );

  vrt_back #(.STEP_LIMIT(STEP_LIMIT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_size_i  (cell_size_q),
    .deq_valid_i  (deq_valid),
    .deq_ready_o  (deq_ready),
    .deq_req_i    (deq_req),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule

FILE: dv/voxel_ray_traversal_tb.sv
`timescale 1ns / 1ps
module voxel_ray_traversal_tb;
  import vrt_pkg::*;

  localparam int unsigned LIMIT = 100;
  localparam logic [24:0] ONE = 25'h100_0000;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic [1:0]  axis;
  } voxel_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cell_size_we_i = 1'b0;
  logic [23:0]  cell_size_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  voxel_ray_traversal #(.STEP_LIMIT(LIMIT)) DUT (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [23:0]        size_q = 24'd6554;
  logic [15:0]        idx_q [3];
  logic [24:0]        frac_q [3];
  logic signed [17:0] dir_q [3];
  int unsigned        steps_q;

  voxel_t      voxels_due [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned seen = 0;
  bit          hold_off = 1'b0;

  // Update the model for one request and queue any voxel it reports
  task automatic trace_model(input logic cmd, input logic [31:0] org [3],
                             input logic [17:0] dv [3]);
    longint signed num, q, sz;
    logic [63:0] mag, rem, t, best_t, delta, f;
    int best;
    voxel_t v;
    best = -1;
    best_t = 0;
    if (cmd == CMD_START) begin
      sz = (size_q == 0) ? 1 : size_q;
      for (int a = 0; a < 3; a++) begin
        num = longint'($signed(org[a])) * 64'sd16777216;
        if (num >= 0) q = num / sz;
        else q = -((-num + sz - 1) / sz);
        idx_q[a] = q[39:24];
        frac_q[a] = {1'b0, q[23:0]};
        dir_q[a] = dv[a];
      end
      steps_q = 0;
      return;
    end
    if (steps_q >= LIMIT) return;
    steps_q++;
    for (int a = 0; a < 3; a++) begin
      if (dir_q[a] == 0) continue;
      mag = (dir_q[a] < 0) ? -longint'(dir_q[a]) : longint'(dir_q[a]);
      rem = (dir_q[a] < 0) ? frac_q[a] : ONE - frac_q[a];
      t = (rem << 16) / mag;
      if (best < 0 || t < best_t) begin
        best = a;
        best_t = t;
      end
    end
    v.vx = idx_q[0];
    v.vy = idx_q[1];
    v.vz = idx_q[2];
    v.axis = (best < 0) ? 2'd0 : 2'(best);
    voxels_due = {voxels_due, v};
    if (best < 0) return;
    for (int a = 0; a < 3; a++) begin
      if (a == best || dir_q[a] == 0) continue;
      mag = (dir_q[a] < 0) ? -longint'(dir_q[a]) : longint'(dir_q[a]);
      delta = (best_t * mag) >> 16;
      f = frac_q[a];
      if (dir_q[a] > 0) f = (f + delta > ONE) ? ONE : f + delta;
      else f = (f >= delta) ? f - delta : 0;
      frac_q[a] = f[24:0];
    end
    if (dir_q[best] > 0) begin
      idx_q[best] = idx_q[best] + 16'd1;
      frac_q[best] = '0;
    end else begin
      idx_q[best] = idx_q[best] - 16'd1;
      frac_q[best] = ONE;
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(input logic cmd, input logic [31:0] org [3],
                              input logic [17:0] dv [3]);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, dv[2], dv[1], dv[0], org[2], org[1], org[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    trace_model(cmd, org, dv);
    sent++;
  endtask

  task automatic send_start(input logic [31:0] ox, oy, oz, input logic [17:0] dx, dy, dz);
    logic [31:0] org [3];
    logic [17:0] dv [3];
    org = '{ox, oy, oz};
    dv = '{dx, dy, dz};
    send_request(CMD_START, org, dv);
  endtask

  task automatic send_step();
    logic [31:0] org [3];
    logic [17:0] dv [3];
    for (int a = 0; a < 3; a++) begin
      org[a] = $urandom;
      dv[a] = 18'($urandom);
    end
    send_request(CMD_STEP, org, dv);
  endtask

  // Drain, let the engine settle, then write the voxel size
  task automatic set_cell_size(input logic [23:0] val);
    s_axis_tvalid <= 1'b0;
    wait (voxels_due.size() == 0);
    repeat (400) @(posedge clk_i);
    cell_size_we_i <= 1'b1;
    cell_size_i <= val;
    @(posedge clk_i);
    cell_size_we_i <= 1'b0;
    size_q = val;
  endtask

  function automatic logic [17:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 18'h0;
      1: return 18'h1FFFF;
      2: return 18'h20000;
      default: return 18'($urandom);
    endcase
  endfunction

  // Receiver with random stalls
  initial begin
    int unsigned g;
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else begin
        g = gap_len();
        m_axis_tready <= (g == 0);
      end
    end
  end

  // Compare each accepted voxel with the oldest prediction
  always @(posedge clk_i) begin
    voxel_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen++;
      if (voxels_due.size() == 0) begin
        $error("unexpected voxel %h axis %0d", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = voxels_due.pop_front();
        if (m_axis_tdata[15:0] !== e.vx) begin
          $error("voxel_x exp %h got %h", e.vx, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tdata[31:16] !== e.vy) begin
          $error("voxel_y exp %h got %h", e.vy, m_axis_tdata[31:16]); errors++;
        end
        if (m_axis_tdata[47:32] !== e.vz) begin
          $error("voxel_z exp %h got %h", e.vz, m_axis_tdata[47:32]); errors++;
        end
        if (m_axis_tuser !== e.axis) begin
          $error("axis_stepped exp %0d got %0d", e.axis, m_axis_tuser); errors++;
        end
      end
    end
  end

  // Extremes, all-zero direction, step before start, ties, wrap, step limit
  task automatic test_directed();
    send_step();
    send_start(32'h0, 32'h0, 32'h0, 18'h0, 18'h0, 18'h0);
    send_step();
    send_start(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 18'h1FFFF, 18'h20000, 18'h1);
    repeat (4) send_step();
    send_start(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 18'h10000, 18'h10000, 18'h10000);
    repeat (4) send_step();
    send_start(32'h0, 32'h0, 32'h0, 18'h0, 18'h0, 18'h3FFFF);
    repeat (3) send_step();
    send_start(32'h1234_5678, 32'hCAFE_0000, 32'h0, 18'h0, 18'h10000, 18'h0);
    repeat (LIMIT + 3) send_step();
  endtask

  task automatic test_cell_sizes();
    logic [23:0] sizes [4];
    sizes = '{24'h0, 24'h1, 24'hFFFFFF, 24'h010000};
    foreach (sizes[i]) begin
      set_cell_size(sizes[i]);
      send_start($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir());
      repeat (3) send_step();
    end
  endtask

  // Random rays of random length, some rays run past the limit
  task automatic test_random_rays(input int unsigned n);
    int unsigned len;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0)
        set_cell_size(($urandom_range(0, 1) == 0) ? 24'($urandom_range(1, 24'h40000))
                                                  : 24'($urandom));
      send_start($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(LIMIT, LIMIT + 5)
                                        : $urandom_range(1, 20);
      repeat (len) send_step();
    end
  endtask

  // Block the receiver long enough that the input queue fills and stalls
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_start($urandom, $urandom, $urandom, 18'h08000, 18'h3C000, 18'h01000);
        repeat (12) send_step();
      end
    join
  endtask

  initial begin
    idx_q = '{default: '0};
    frac_q = '{default: '0};
    dir_q = '{default: '0};
    steps_q = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_cell_sizes();
    test_backpressure();
    test_random_rays(1100);
    s_axis_tvalid <= 1'b0;
    wait (voxels_due.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d voxels across start, step, limit and size cases.",
             sent, seen);
    if (errors == 0) $display("voxel_ray_traversal_tb: PASS");
    else $display("voxel_ray_traversal_tb: FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("voxel_ray_traversal_tb: FAIL");
    $finish;
  end

endmodule
